// ===== hw/rtl/spq_pkg.sv =====
// Package for the stable priority queue: entry, transaction and link types,
// operation and status codes, and the grade helper functions.
// Used by spq_cell and stable_priority_queue_with_filters.
package spq_pkg;

  // One stored queue entry.
  typedef struct packed {
    logic [15:0] rec;
    logic [7:0]  grade;
    logic [9:0]  gpa;
    logic [7:0]  tries;
  } entry_t;

  // Input transaction.
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] record_id;
    logic [7:0]  grade_letter;
    logic [9:0]  gpa_value;
    logic [7:0]  attempt_count;
    logic [9:0]  min_gpa;
    logic [7:0]  min_grade;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_record_id;
    logic [7:0]  out_grade;
    logic [9:0]  out_gpa;
    logic [7:0]  out_attempts;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_POP        = 3'd1,
    OP_LIST_ALL   = 3'd2,
    OP_LIST_GPA   = 3'd3,
    OP_LIST_GRADE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_ITEM  = 3'd3,
    ST_END   = 3'd4
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    ins;
  } cell_ctl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic   valid;
    logic   keep;
    entry_t ent;
  } link_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_END
  } fsm_e;

  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharB     = 8'h42;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CaseShift = 8'h20;

  // Only ASCII lower-case letters change.
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharLowA && c <= CharLowZ) begin
      r = c - CaseShift;
    end
    return r;
  endfunction

  // A ranks 5 down to F at 1; anything else ranks 0.
  function automatic logic [2:0] grade_rank(input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] r;
    u = to_upper(c);
    unique case (u)
      CharA:   r = 3'd5;
      CharB:   r = 3'd4;
      CharC:   r = 3'd3;
      CharD:   r = 3'd2;
      CharF:   r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/stable_priority_queue_with_filters.sv =====
// Top level of the stable priority queue: cell chain, controller and output register.
// Depends on spq_pkg and spq_cell.
//
// Usage: one input transaction on in_i (valid/stall) performs one operation:
// insert, pop head, list all, list by minimum GPA or list by minimum grade.
// Results leave on out_o (valid/stall); out_o.last marks the final result of
// each input transaction.
// Insert, pop and unused opcodes: the result is registered at the accepting
// edge and shows on out_o after it; the next input can be accepted in the
// following cycle unless the receiver stalls that result.
// A list rotates the whole chain of QUEUE_DEPTH cells once through cell 0,
// one step per free output slot, then sends the end-of-list result; the
// input is stalled throughout.
// When the receiver stalls, the chain holds and the result register keeps
// its transaction; in_stall_o rises as soon as the result register is full
// and stalled.
// Reset empties the queue (all cell valid bits cleared) and drops any
// pending result.
module stable_priority_queue_with_filters #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::out_t out_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH);
  localparam logic [CntW-1:0] CntLast = CntW'(QUEUE_DEPTH - 1);

  spq_pkg::fsm_e      state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [2:0]         lop_q, lop_d;
  logic [9:0]         min_gpa_q, min_gpa_d;
  logic [2:0]         min_rank_q, min_rank_d;
  logic               out_valid_q, out_valid_d;
  spq_pkg::out_t      out_q, out_d;
  logic               load_out;
  logic               out_ready;
  logic               in_acc;
  logic               hit;
  logic               full;
  logic               empty;
  logic [QUEUE_DEPTH-1:0] occ;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::link_t     lnk      [QUEUE_DEPTH];
  spq_pkg::link_t     left_in  [QUEUE_DEPTH];
  spq_pkg::link_t     right_in [QUEUE_DEPTH];

  // Handshake.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != spq_pkg::S_IDLE) || !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Neighbor wiring: cell 0 sees an always-kept left side; the last cell
  // sees cell 0 on its right during a scan (rotation), an empty slot otherwise.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i] = lnk[i].valid;
      if (i == 0) begin
        left_in[i].valid = 1'b1;
        left_in[i].keep  = 1'b1;
        left_in[i].ent   = '0;
      end else begin
        left_in[i] = lnk[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin
        right_in[i].valid = lnk[0].valid && (state_q == spq_pkg::S_SCAN);
        right_in[i].keep  = 1'b0;
        right_in[i].ent   = lnk[0].ent;
      end else begin
        right_in[i] = lnk[i+1];
      end
    end
  end

  assign full  = occ[QUEUE_DEPTH-1];
  assign empty = !occ[0];

  // The chain of cells.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .left_i  (left_in[g]),
      .right_i (right_in[g]),
      .cell_o  (lnk[g])
    );
  end

  // Filter match for the entry at the head during a scan.
  always_comb begin
    unique case (lop_q)
      spq_pkg::OP_LIST_GPA:   hit = lnk[0].ent.gpa >= min_gpa_q;
      spq_pkg::OP_LIST_GRADE: hit = spq_pkg::grade_rank(lnk[0].ent.grade) >= min_rank_q;
      default:                hit = 1'b1;
    endcase
  end

  // Controller: next state, chain command and result.
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    lop_d          = lop_q;
    min_gpa_d      = min_gpa_q;
    min_rank_d     = min_rank_q;
    ctl.cmd        = spq_pkg::CELL_HOLD;
    ctl.ins.rec    = in_i.record_id;
    ctl.ins.grade  = spq_pkg::to_upper(in_i.grade_letter);
    ctl.ins.gpa    = in_i.gpa_value;
    ctl.ins.tries  = in_i.attempt_count;
    load_out       = 1'b0;
    out_d          = '0;
    out_d.last     = 1'b1;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.op)
            spq_pkg::OP_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                out_d.status = spq_pkg::ST_FULL;
              end else begin
                ctl.cmd      = spq_pkg::CELL_INSERT;
                out_d.status = spq_pkg::ST_DONE;
              end
            end
            spq_pkg::OP_POP: begin
              load_out = 1'b1;
              if (empty) begin
                out_d.status = spq_pkg::ST_EMPTY;
              end else begin
                ctl.cmd             = spq_pkg::CELL_SHIFT;
                out_d.status        = spq_pkg::ST_DONE;
                out_d.out_record_id = lnk[0].ent.rec;
                out_d.out_grade     = lnk[0].ent.grade;
                out_d.out_gpa       = lnk[0].ent.gpa;
                out_d.out_attempts  = lnk[0].ent.tries;
              end
            end
            spq_pkg::OP_LIST_ALL, spq_pkg::OP_LIST_GPA, spq_pkg::OP_LIST_GRADE: begin
              lop_d      = in_i.op;
              min_gpa_d  = in_i.min_gpa;
              min_rank_d = spq_pkg::grade_rank(in_i.min_grade);
              cnt_d      = '0;
              state_d    = spq_pkg::S_SCAN;
            end
            default: begin
              load_out     = 1'b1;
              out_d.status = spq_pkg::ST_DONE;
            end
          endcase
        end
      end
      spq_pkg::S_SCAN: begin
        // Rotate one step per free output slot; matching entries are sent.
        if (out_ready) begin
          ctl.cmd = spq_pkg::CELL_SHIFT;
          if (lnk[0].valid && hit) begin
            load_out            = 1'b1;
            out_d.status        = spq_pkg::ST_ITEM;
            out_d.out_record_id = lnk[0].ent.rec;
            out_d.out_grade     = lnk[0].ent.grade;
            out_d.out_gpa       = lnk[0].ent.gpa;
            out_d.out_attempts  = lnk[0].ent.tries;
            out_d.last          = 1'b0;
          end
          if (cnt_q == CntLast) begin
            state_d = spq_pkg::S_END;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      spq_pkg::S_END: begin
        if (out_ready) begin
          load_out     = 1'b1;
          out_d.status = spq_pkg::ST_END;
          state_d      = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Result register valid: set on load, cleared once the transaction is taken.
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lop_q      <= lop_d;
    min_gpa_q  <= min_gpa_d;
    min_rank_q <= min_rank_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  // Between operations the occupied cells form a prefix of the chain.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::S_IDLE) |-> (((occ >> 1) & ~occ) == '0))
    else $error("occupied cells are not a prefix of the chain");

  // A scan rotates entries and never changes how many are stored.
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::S_SCAN) |=> ($countones(occ) == $past($countones(occ))))
    else $error("entry count changed during a list scan");

  // An accepted insert into a queue with room adds exactly one entry.
  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.op == spq_pkg::OP_INSERT) && !full)
      |=> ($countones(occ) == $past($countones(occ)) + 1))
    else $error("insert did not add exactly one entry");

  // The end-of-list result closes the list transaction.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == spq_pkg::S_END) && out_ready)
      |=> (out_valid_o && out_o.last && (out_o.status == spq_pkg::ST_END)))
    else $error("end of list not delivered with last set");

  // No input is taken while a list is in progress.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spq_pkg::S_IDLE) |-> in_stall_o)
    else $error("input not stalled during a list");
`endif

endmodule

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on spq_pkg for the entry, command and link types.
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  spq_pkg::link_t    left_i,
  input  spq_pkg::link_t    right_i,
  output spq_pkg::link_t    cell_o
);

  logic            valid_q, valid_d;
  spq_pkg::entry_t ent_q, ent_d;
  logic            keep;

  // An entry stays put on insert when its count is at least the new one.
  assign keep = valid_q && (ent_q.tries >= ctl_i.ins.tries);

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    unique case (ctl_i.cmd)
      spq_pkg::CELL_INSERT: begin
        if (!keep) begin
          if (left_i.keep) begin
            valid_d = 1'b1;
            ent_d   = ctl_i.ins;
          end else begin
            valid_d = left_i.valid;
            ent_d   = left_i.ent;
          end
        end
      end
      spq_pkg::CELL_SHIFT: begin
        valid_d = right_i.valid;
        ent_d   = right_i.ent;
      end
      default: begin
      end
    endcase
  end

  // Valid bit is control state; the entry itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.keep  = keep;
  assign cell_o.ent   = ent_q;

endmodule

// ===== tb/stable_priority_queue_with_filters_test.sv =====
// Self-checking testbench for stable_priority_queue_with_filters: directed table, then random traffic.
// A shadow queue in the testbench predicts every result. Depends on spq_pkg and the queue RTL.
`timescale 1ns / 100ps

module stable_priority_queue_with_filters_test;

  localparam int QueueDepth  = 32;
  localparam int RandomItems = 405;
  localparam int CycleLimit  = 800000;

  // Opcodes that the block treats as no-ops.
  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam spq_pkg::out_t DoneRes  =
    '{spq_pkg::ST_DONE, 16'd0, 8'd0, 10'd0, 8'd0, 1'b1};
  localparam spq_pkg::out_t EmptyRes =
    '{spq_pkg::ST_EMPTY, 16'd0, 8'd0, 10'd0, 8'd0, 1'b1};
  localparam spq_pkg::out_t EndRes   =
    '{spq_pkg::ST_END, 16'd0, 8'd0, 10'd0, 8'd0, 1'b1};

  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIXED
  } traffic_e;

  // One row of the directed table; golden_res is used only where has_golden is set.
  typedef struct packed {
    spq_pkg::in_t  item;
    bit            has_golden;
    spq_pkg::out_t golden_res;
  } stim_row_t;

  localparam int NumDirected = 23;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  spq_pkg::in_t  in_i;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  spq_pkg::out_t out_o;

  spq_pkg::entry_t shadow_entries[$];
  spq_pkg::out_t   awaited_results[$];
  int     fail_count  = 0;
  int     cycle_count = 0;
  int     burst_left  = 0;

  stim_row_t directed_rows [NumDirected] = '{
    '{'{spq_pkg::OP_POP, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b1, EmptyRes},
    '{'{spq_pkg::OP_LIST_ALL, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b1, EndRes},
    '{'{OpSpare5, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'hffff, "a", 10'd1023, 8'd255, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h0000, "F", 10'd0, 8'd0, 10'd1023, 8'hff}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h1234, "b", 10'd350, 8'd7, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h1235, "C", 10'd350, 8'd7, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h0002, "z", 10'd200, 8'd7, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h0003, 8'hff, 10'd512, 8'd200, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h0004, "d", 10'd1, 8'd0, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_INSERT, 16'h0005, "e", 10'd999, 8'd254, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_LIST_ALL, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GPA, 16'd0, 8'd0, 10'd0, 8'd0, 10'd350, 8'd0}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GPA, 16'd0, 8'd0, 10'd0, 8'd0, 10'd1023, 8'd0}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GPA, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GRADE, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, "c"}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GRADE, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, "A"}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GRADE, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, "x"}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_GRADE, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, "f"}, 1'b0, '0},
    '{'{OpSpare6, 16'hffff, 8'hff, 10'd1023, 8'hff, 10'd1023, 8'hff}, 1'b1, DoneRes},
    '{'{OpSpare7, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b1, DoneRes},
    '{'{spq_pkg::OP_POP, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b0, '0},
    '{'{spq_pkg::OP_LIST_ALL, 16'd0, 8'd0, 10'd0, 8'd0, 10'd0, 8'd0}, 1'b0, '0}
  };

  stable_priority_queue_with_filters #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Upper-case ASCII letters by clearing bit 5; other bytes pass through.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? (c & 8'hdf) : c;
  endfunction

  function automatic int letter_rank(input logic [7:0] c);
    int rank;
    case (fold_case(c))
      spq_pkg::CharA: rank = 5;
      spq_pkg::CharB: rank = 4;
      spq_pkg::CharC: rank = 3;
      spq_pkg::CharD: rank = 2;
      spq_pkg::CharF: rank = 1;
      default:        rank = 0;
    endcase
    return rank;
  endfunction

  // Apply one accepted request to the shadow queue and queue up its results.
  task automatic predict_results(input spq_pkg::in_t req);
    spq_pkg::entry_t ent;
    spq_pkg::out_t   res;
    spq_pkg::out_t   item_res;
    int     pos;
    int     floor_rank;
    bit     hit;
    res      = '0;
    res.last = 1'b1;
    case (req.op)
      spq_pkg::OP_INSERT: begin
        if (shadow_entries.size() >= QueueDepth) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          ent.rec   = req.record_id;
          ent.grade = fold_case(req.grade_letter);
          ent.gpa   = req.gpa_value;
          ent.tries = req.attempt_count;
          // Equal counts go behind the ones already queued.
          pos = 0;
          while (pos < shadow_entries.size() && shadow_entries[pos].tries >= ent.tries) begin
            pos++;
          end
          shadow_entries.insert(pos, ent);
          res.status = spq_pkg::ST_DONE;
        end
        awaited_results.push_back(res);
      end
      spq_pkg::OP_POP: begin
        if (shadow_entries.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          ent               = shadow_entries.pop_front();
          res.status        = spq_pkg::ST_DONE;
          res.out_record_id = ent.rec;
          res.out_grade     = ent.grade;
          res.out_gpa       = ent.gpa;
          res.out_attempts  = ent.tries;
        end
        awaited_results.push_back(res);
      end
      spq_pkg::OP_LIST_ALL, spq_pkg::OP_LIST_GPA, spq_pkg::OP_LIST_GRADE: begin
        floor_rank = letter_rank(req.min_grade);
        foreach (shadow_entries[i]) begin
          hit = 1'b1;
          if (req.op == spq_pkg::OP_LIST_GPA) begin
            hit = shadow_entries[i].gpa >= req.min_gpa;
          end else if (req.op == spq_pkg::OP_LIST_GRADE) begin
            hit = letter_rank(shadow_entries[i].grade) >= floor_rank;
          end
          if (hit) begin
            item_res               = '0;
            item_res.status        = spq_pkg::ST_ITEM;
            item_res.out_record_id = shadow_entries[i].rec;
            item_res.out_grade     = shadow_entries[i].grade;
            item_res.out_gpa       = shadow_entries[i].gpa;
            item_res.out_attempts  = shadow_entries[i].tries;
            item_res.last          = 1'b0;
            awaited_results.push_back(item_res);
          end
        end
        res.status = spq_pkg::ST_END;
        awaited_results.push_back(res);
      end
      default: begin
        res.status = spq_pkg::ST_DONE;
        awaited_results.push_back(res);
      end
    endcase
  endtask

  // Grade bytes: mostly ranked or near-ranked letters in either case, some raw bytes.
  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = spq_pkg::CharA;
      1:       c = spq_pkg::CharB;
      2:       c = spq_pkg::CharC;
      3:       c = spq_pkg::CharD;
      4:       c = spq_pkg::CharF;
      default: c = "E";
    endcase
    if ($urandom_range(0, 1) == 1) begin
      c = c + spq_pkg::CaseShift;
    end
    if ($urandom_range(0, 9) < 3) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Random request; the traffic mix steers the queue toward full, empty or neither.
  function automatic spq_pkg::in_t random_request(input traffic_e mix);
    spq_pkg::in_t req;
    int  roll;
    int  ins_cut;
    int  pop_cut;
    roll = $urandom_range(0, 99);
    case (mix)
      TRAFFIC_FILL: begin
        ins_cut = 70;
        pop_cut = 80;
      end
      TRAFFIC_DRAIN: begin
        ins_cut = 15;
        pop_cut = 75;
      end
      default: begin
        ins_cut = 35;
        pop_cut = 65;
      end
    endcase
    req.record_id     = 16'($urandom);
    req.grade_letter  = pick_letter();
    req.gpa_value     = 10'($urandom_range(0, 1023));
    // Small counts give many ties, which checks first-come-first-served order.
    req.attempt_count = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom_range(0, 255));
    req.min_gpa       = 10'($urandom_range(0, 1023));
    req.min_grade     = pick_letter();
    if (roll < ins_cut) begin
      req.op = spq_pkg::OP_INSERT;
    end else if (roll < pop_cut) begin
      req.op = spq_pkg::OP_POP;
    end else if (roll < 95) begin
      case ($urandom_range(0, 2))
        0:       req.op = spq_pkg::OP_LIST_ALL;
        1:       req.op = spq_pkg::OP_LIST_GPA;
        default: req.op = spq_pkg::OP_LIST_GRADE;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       req.op = OpSpare5;
        1:       req.op = OpSpare6;
        default: req.op = OpSpare7;
      endcase
    end
    return req;
  endfunction

  // Send one transaction in bursts with random gaps; predict it once accepted.
  task automatic offer_request(input spq_pkg::in_t req);
    int gap;
    bit accepted;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    // Stall is sampled mid-cycle; it only moves after a rising edge.
    do begin
      @(negedge clk_i);
      accepted = !in_stall_o;
      @(posedge clk_i);
    end while (!accepted);
    predict_results(req);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Check each result transaction that the next rising edge will accept.
  always @(negedge clk_i) begin
    spq_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0h record %0h", out_o.status, out_o.out_record_id);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", 16'(want.status), 16'(out_o.status));
        compare_field("out_record_id", want.out_record_id, out_o.out_record_id);
        compare_field("out_grade", 16'(want.out_grade), 16'(out_o.out_grade));
        compare_field("out_gpa", 16'(want.out_gpa), 16'(out_o.out_gpa));
        compare_field("out_attempts", 16'(want.out_attempts), 16'(out_o.out_attempts));
        compare_field("last", 16'(want.last), 16'(out_o.last));
      end
    end
  end

  // Receiver stall pattern: free-running, sparse random, long holds, periodic.
  int stall_mode  = 0;
  int mode_left   = 0;
  int hold_left   = 0;
  int stall_phase = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: begin
          if (hold_left == 0) begin
            out_stall_i <= !out_stall_i;
            hold_left = out_stall_i ? $urandom_range(1, 4) : $urandom_range(1, 8);
          end
          hold_left--;
        end
        default: out_stall_i <= (stall_phase % 3 == 0);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("stable_priority_queue_with_filters regression: fail");
      $finish;
    end
  end

  initial begin
    traffic_e mix;
    int       sent;
    int       seg_left;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed-in results replace the prediction for their row.
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].item);
      if (directed_rows[i].has_golden) begin
        awaited_results[awaited_results.size() - 1] = directed_rows[i].golden_res;
      end
    end

    // Random traffic in segments of one mix each.
    sent = 0;
    while (sent < RandomItems) begin
      mix      = traffic_e'($urandom_range(0, 2));
      seg_left = $urandom_range(20, 60);
      while (seg_left > 0 && sent < RandomItems) begin
        offer_request(random_request(mix));
        seg_left--;
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (QueueDepth + 8) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("stable_priority_queue_with_filters regression: pass");
    end else begin
      $display("stable_priority_queue_with_filters regression: fail");
    end
    $finish;
  end

endmodule
